>>> hw/rtl/ncf_pkg.sv
// Package for the negative cycle finder: sizes, constants, state encoding.
// No dependencies.
`default_nettype none
package ncf_pkg;
  localparam int MaxNodes  = 32;
  localparam int MaxEdges  = 256;
  localparam int NodeW     = 6;
  localparam int DistW     = 48;
  localparam int WeightW   = 32;
  localparam int EdgeAw    = $clog2(MaxEdges);
  localparam int EdgeCntW  = EdgeAw + 1;
  localparam int EdgeW     = 2 * NodeW + WeightW;
  localparam int NodeAw    = $clog2(MaxNodes + 1);
  localparam int PathAw    = $clog2(MaxNodes + 2);
  localparam int NodeMemD  = MaxNodes + 1;
  localparam int PathMemD  = MaxNodes + 1;
  localparam int DistEntW  = DistW + 1;

  localparam logic [DistW-1:0] DistMax = {1'b0, {(DistW-1){1'b1}}};
  localparam logic [DistW-1:0] DistMin = {1'b1, {(DistW-1){1'b0}}};

  localparam logic [0:0] RegNodeCount  = 1'b0;
  localparam logic [0:0] RegSourceNode = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_INIT, ST_RD_EDGE, ST_RD_DIST, ST_RELAX, ST_PASS_END,
    ST_WALK_RD, ST_WALK, ST_COL_RD, ST_COL, ST_EMIT_RD, ST_EMIT, ST_NONE
  } state_t;

  typedef struct packed {
    logic [NodeW-1:0]   from;
    logic [NodeW-1:0]   to;
    logic [WeightW-1:0] weight;
  } edge_t;

  // Saturating add of a distance and a sign-extended weight.
  function automatic logic [DistW-1:0] sat_add(input logic [DistW-1:0] d,
                                               input logic [WeightW-1:0] w);
    logic [DistW:0] s;
    begin
      s = {d[DistW-1], d} + {{(DistW-WeightW+1){w[WeightW-1]}}, w};
      if (s[DistW] != s[DistW-1]) begin
        sat_add = s[DistW] ? DistMin : DistMax;
      end else begin
        sat_add = s[DistW-1:0];
      end
    end
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/ncf_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module ncf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(Depth)-1:0] waddr,
  input  wire [Width-1:0]         wdata,
  input  wire [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]        rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/ncf_cfg.sv
// APB-style configuration registers: node count and source node.
// Depends on ncf_pkg.
`default_nettype none
module ncf_cfg (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire [2:0]                 paddr,
  input  wire [31:0]                pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [ncf_pkg::NodeW-1:0] node_count,
  output logic [ncf_pkg::NodeW-1:0] source_node
);
  import ncf_pkg::*;
  logic [NodeW-1:0] count_r, source_r;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && (paddr[1:0] == 2'b00);

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= NodeW'(32);
      source_r <= NodeW'(1);
    end else if (wr && paddr[2] == RegNodeCount) begin
      count_r <= pwdata[NodeW-1:0];
    end else if (wr && paddr[2] == RegSourceNode) begin
      source_r <= pwdata[NodeW-1:0];
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      prdata[NodeW-1:0] = (paddr[2] == RegNodeCount) ? count_r : source_r;
    end
  end

  assign node_count  = count_r;
  assign source_node = source_r;
endmodule
`default_nettype wire

>>> hw/rtl/negative_cycle_finder_top.sv
// Top level of the negative cycle finder: sequencer, edge/distance/predecessor
// /path memories. Depends on ncf_pkg, ncf_ram and ncf_cfg.
//
// Usage: raise start with an edge while busy is low; each edge is stored, up
// to 256. The edge with in_last_edge set starts a run of node_count (clamped
// to 2..32) Bellman-Ford passes over all stored edges (in load order), after
// the distance and predecessor memories are cleared with only the source node
// marked reached (if in 1..node_count). Per pass, each edge goes through edge
// read, tail distance read and skip, or, when its tail is reached and both
// endpoints are in range, head distance read, relax and write back; edges go
// one at a time, as the distance memory has one read port. The predecessor
// walk then steps back from the last relaxed node and the cycle is collected
// node by node. Results come out on the out_ ports, each marked by out_valid
// for one cycle: the cycle nodes in forward order with the start repeated,
// the nodes collected up to a zero predecessor or a full path buffer, or one
// not-found result. The receiver cannot stall; results must be taken.
// busy is high from the last edge until the final result has gone out.
// Reset (rst_n low, synchronous) empties the edge store and restores
// node_count = 32, source_node = 1. Configure only while idle.
`default_nettype none
module negative_cycle_finder_top (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  output logic                      busy,
  input  wire [ncf_pkg::NodeW-1:0]  in_edge_from,
  input  wire [ncf_pkg::NodeW-1:0]  in_edge_to,
  input  wire signed [ncf_pkg::WeightW-1:0] in_edge_weight,
  input  wire                       in_last_edge,
  output logic                      out_valid,
  output logic                      out_cycle_found,
  output logic [ncf_pkg::NodeW-1:0] out_cycle_node,
  output logic                      out_last_result,
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire [2:0]                 paddr,
  input  wire [31:0]                pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import ncf_pkg::*;

  logic [NodeW-1:0] cfg_node_count, cfg_source_node;

  ncf_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .node_count(cfg_node_count), .source_node(cfg_source_node)
  );

  state_t state_r, state_nxt;
  logic [EdgeCntW-1:0] total_r, total_nxt;
  logic [EdgeCntW-1:0] eidx_r, eidx_nxt;
  logic [NodeW-1:0]    pass_r, pass_nxt;
  logic [NodeW-1:0]    n_r, n_nxt;
  logic [NodeW-1:0]    lastrel_r, lastrel_nxt;
  logic [NodeW-1:0]    cur_r, cur_nxt;
  logic [NodeW-1:0]    startn_r, startn_nxt;
  logic [PathAw-1:0]   plen_r, plen_nxt;
  logic [PathAw-1:0]   pk_r, pk_nxt;
  logic [NodeAw:0]     init_r, init_nxt;
  logic [DistW-1:0]    du_r, du_nxt;
  logic                ru_r, ru_nxt;
  edge_t               e_r, e_nxt;

  // Edge store
  logic          e_we;
  logic [EdgeAw-1:0] e_waddr;
  edge_t         e_wdata, e_rdata;
  ncf_ram #(.Width(EdgeW), .Depth(MaxEdges)) u_edges (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(eidx_r[EdgeAw-1:0]), .rdata(e_rdata)
  );

  // Distance store: {reached, distance}
  logic                d_we;
  logic [NodeAw-1:0]   d_waddr, d_raddr;
  logic [DistEntW-1:0] d_wdata, d_rdata;
  ncf_ram #(.Width(DistEntW), .Depth(NodeMemD)) u_dist (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  // Predecessor store
  logic              p_we;
  logic [NodeAw-1:0] p_waddr, p_raddr;
  logic [NodeW-1:0]  p_wdata, p_rdata;
  ncf_ram #(.Width(NodeW), .Depth(NodeMemD)) u_pred (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  // Path buffer
  logic              b_we;
  logic [PathAw-1:0] b_waddr, b_raddr;
  logic [NodeW-1:0]  b_wdata, b_rdata;
  ncf_ram #(.Width(NodeW), .Depth(PathMemD)) u_path (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  logic             accept;
  logic             e_valid;
  logic [DistW-1:0] cand;
  logic             relax;

  assign accept = start && !busy;
  assign e_valid = (e_r.from != '0) && (e_r.from <= n_r) &&
                   (e_r.to != '0) && (e_r.to <= n_r);
  assign cand  = sat_add(du_r, e_r.weight);
  assign relax = ru_r && (!d_rdata[DistW] ||
                 ($signed(cand) < $signed(d_rdata[DistW-1:0])));

  // Next state and datapath
  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r; eidx_nxt = eidx_r; pass_nxt = pass_r; n_nxt = n_r;
    lastrel_nxt = lastrel_r; cur_nxt = cur_r; startn_nxt = startn_r;
    plen_nxt = plen_r; pk_nxt = pk_r; init_nxt = init_r;
    du_nxt = du_r; ru_nxt = ru_r; e_nxt = e_r;
    e_we = 1'b0; e_waddr = total_r[EdgeAw-1:0];
    e_wdata = '{from: in_edge_from, to: in_edge_to, weight: in_edge_weight};
    d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_raddr = '0;
    p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_raddr = cur_r[NodeAw-1:0];
    b_we = 1'b0; b_waddr = pk_r; b_wdata = cur_r; b_raddr = pk_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (total_r < EdgeCntW'(MaxEdges)) begin
            e_we = 1'b1;
            total_nxt = total_r + 1'b1;
          end
          if (in_last_edge) begin
            if (cfg_node_count < NodeW'(2)) n_nxt = NodeW'(2);
            else if (cfg_node_count > NodeW'(MaxNodes)) n_nxt = NodeW'(MaxNodes);
            else n_nxt = cfg_node_count;
            init_nxt = '0;
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        // Clear distance and predecessor entries one a cycle
        d_we = 1'b1; p_we = 1'b1;
        d_waddr = init_r[NodeAw-1:0]; p_waddr = init_r[NodeAw-1:0];
        d_wdata = {((init_r[NodeAw-1:0] == NodeAw'(cfg_source_node)) &&
                    (cfg_source_node != '0) && (cfg_source_node <= n_r)),
                   {DistW{1'b0}}};
        p_wdata = '0;
        init_nxt = init_r + 1'b1;
        if (init_r == (NodeAw+1)'(NodeMemD - 1)) begin
          pass_nxt = '0; eidx_nxt = '0; lastrel_nxt = '0;
          state_nxt = (total_nxt == '0) ? ST_PASS_END : ST_RD_EDGE;
        end
      end
      ST_RD_EDGE: begin
        state_nxt = ST_RD_DIST;
      end
      ST_RD_DIST: begin
        e_nxt = e_rdata;
        d_raddr = e_rdata.from[NodeAw-1:0];
        state_nxt = ST_RELAX;
      end
      ST_RELAX: begin
        // Tail distance arrives first; fetch head distance next
        if (!ru_r) begin
          du_nxt = d_rdata[DistW-1:0];
          ru_nxt = d_rdata[DistW] && e_valid;
          d_raddr = e_r.to[NodeAw-1:0];
          if (d_rdata[DistW] && e_valid) begin
            state_nxt = ST_RELAX;
          end else begin
            ru_nxt = 1'b0;
            eidx_nxt = eidx_r + 1'b1;
            state_nxt = (eidx_r + 1'b1 == total_r) ? ST_PASS_END : ST_RD_EDGE;
          end
        end else begin
          ru_nxt = 1'b0;
          if (relax) begin
            d_we = 1'b1; d_waddr = e_r.to[NodeAw-1:0]; d_wdata = {1'b1, cand};
            p_we = 1'b1; p_waddr = e_r.to[NodeAw-1:0]; p_wdata = e_r.from;
            lastrel_nxt = e_r.to;
          end
          eidx_nxt = eidx_r + 1'b1;
          state_nxt = (eidx_r + 1'b1 == total_r) ? ST_PASS_END : ST_RD_EDGE;
        end
      end
      ST_PASS_END: begin
        eidx_nxt = '0;
        pass_nxt = pass_r + 1'b1;
        if (pass_r + 1'b1 == n_r) begin
          if (lastrel_r == '0) begin
            state_nxt = ST_NONE;
          end else begin
            cur_nxt = lastrel_r; pass_nxt = NodeW'(1);
            state_nxt = (n_r == NodeW'(1)) ? ST_COL_RD : ST_WALK_RD;
          end
        end else begin
          lastrel_nxt = '0;
          state_nxt = (total_r == '0) ? ST_PASS_END : ST_RD_EDGE;
        end
      end
      ST_WALK_RD: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        // Step back one predecessor
        cur_nxt = p_rdata;
        pass_nxt = pass_r + 1'b1;
        if (pass_r + 1'b1 == n_r) begin
          startn_nxt = p_rdata; pk_nxt = '0;
          state_nxt = ST_COL_RD;
        end else begin
          state_nxt = ST_WALK_RD;
        end
      end
      ST_COL_RD: begin
        if (pass_r == NodeW'(1) && state_r == ST_COL_RD && pk_r == '0 &&
            startn_r != cur_r) begin
          startn_nxt = cur_r;
        end
        if (cur_r == '0 || pk_r == PathAw'(MaxNodes + 1)) begin
          plen_nxt = pk_r;
          state_nxt = (pk_r == '0) ? ST_NONE : ST_EMIT_RD;
          pk_nxt = pk_r - 1'b1;
        end else begin
          b_we = 1'b1;
          pk_nxt = pk_r + 1'b1;
          if (cur_r == startn_r && pk_r != '0) begin
            plen_nxt = pk_r + 1'b1;
            pk_nxt = pk_r;
            state_nxt = ST_EMIT_RD;
          end else begin
            state_nxt = ST_COL;
          end
        end
      end
      ST_COL: begin
        cur_nxt = p_rdata;
        state_nxt = ST_COL_RD;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        pk_nxt = pk_r - 1'b1;
        state_nxt = (pk_r == '0) ? ST_LOAD : ST_EMIT_RD;
        if (pk_r == '0) total_nxt = '0;
      end
      ST_NONE: begin
        total_nxt = '0;
        state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    busy = (state_r != ST_LOAD);
    out_valid = 1'b0; out_cycle_found = 1'b0; out_cycle_node = '0;
    out_last_result = 1'b0;
    unique case (state_r)
      ST_EMIT: begin
        out_valid = 1'b1; out_cycle_found = 1'b1; out_cycle_node = b_rdata;
        out_last_result = (pk_r == '0);
      end
      ST_NONE: begin
        out_valid = 1'b1; out_last_result = 1'b1;
      end
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      total_r <= '0;
      ru_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      ru_r    <= ru_nxt;
    end
    eidx_r <= eidx_nxt; pass_r <= pass_nxt; n_r <= n_nxt;
    lastrel_r <= lastrel_nxt; cur_r <= cur_nxt; startn_r <= startn_nxt;
    plen_r <= plen_nxt; pk_r <= pk_nxt; init_r <= init_nxt;
    du_r <= du_nxt; e_r <= e_nxt;
  end
endmodule
`default_nettype wire
